>>> sv/ptw_pkg.sv
package ptw_pkg;

  localparam int FRAMES_DEF        = 64;
  localparam int ENTRIES_PER_FRAME = 512;
  localparam int IDX_W             = 9;
  localparam int FRAME_NUM_W       = 36;
  localparam int VA_W              = 48;
  localparam int WORD_W            = 64;
  localparam int WIDX_W            = 15;
  localparam int ROOT_W            = 6;
  localparam int CFG_DATA_W        = 32;
  localparam int CFG_ADDR_W        = 3;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_WALK  = 1'b1;

  // status codes
  localparam logic [1:0] ST_WRITE   = 2'd0;
  localparam logic [1:0] ST_LEAF    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_OUTSIDE = 2'd3;

  // walk levels
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_3    = 2'd3;

  // register index (paddr bit 2)
  localparam logic REG_ROOT_FRAME = 1'b0;

  localparam int PRESENT_BIT = 0;
  localparam int FRAME_LSB   = 12;

  typedef struct packed {
    logic [1:0]      status;
    logic [VA_W-1:0] leaf_entry_address;
    logic [1:0]      stop_level;
  } result_t;

endpackage

>>> sv/ptw_store.sv
module ptw_store #(
  parameter int FRAMES = ptw_pkg::FRAMES_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    wr_en,
  input  logic                                                    rd_en,
  input  logic [$clog2(FRAMES*ptw_pkg::ENTRIES_PER_FRAME)-1:0]    addr,
  input  logic [ptw_pkg::WORD_W-1:0]                              wdata,
  output logic [ptw_pkg::WORD_W-1:0]                              rdata
);
  import ptw_pkg::*;

  localparam int DEPTH = FRAMES * ENTRIES_PER_FRAME;

  logic [WORD_W-1:0] mem [0:DEPTH-1];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/ptw_ctrl.sv
module ptw_ctrl #(
  parameter int FRAMES = ptw_pkg::FRAMES_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic [ptw_pkg::ROOT_W-1:0]                              root_frame,
  input  logic                                                    in_valid,
  output logic                                                    in_stall,
  input  logic                                                    in_operation,
  input  logic [ptw_pkg::VA_W-1:0]                                in_virtual_address,
  input  logic [ptw_pkg::WIDX_W-1:0]                              in_word_index,
  input  logic [ptw_pkg::WORD_W-1:0]                              in_word_value,
  output logic                                                    out_valid,
  input  logic                                                    out_stall,
  output ptw_pkg::result_t                                        out_result,
  output logic                                                    mem_wr_en,
  output logic                                                    mem_rd_en,
  output logic [$clog2(FRAMES*ptw_pkg::ENTRIES_PER_FRAME)-1:0]    mem_addr,
  output logic [ptw_pkg::WORD_W-1:0]                              mem_wdata,
  input  logic [ptw_pkg::WORD_W-1:0]                              mem_rdata
);
  import ptw_pkg::*;

  localparam int DEPTH  = FRAMES * ENTRIES_PER_FRAME;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FULL_W = FRAME_NUM_W + IDX_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                result_r, result_nxt;
  logic [VA_W-1:0]        va_r, va_nxt;
  logic [FRAME_NUM_W-1:0] frame_r, frame_nxt;
  logic [1:0]             lvl_r, lvl_nxt;

  logic                   accept;
  logic                   outside;
  logic [IDX_W-1:0]       idx;
  logic [FULL_W-1:0]      walk_full;
  logic [FULL_W-1:0]      write_full;
  logic [FRAME_NUM_W-1:0] entry_frame;

  assign in_stall = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign outside  = frame_r >= FRAME_NUM_W'(FRAMES);

  always_comb begin
    unique case (lvl_r)
      LVL_3:   idx = va_r[47:39];
      LVL_2:   idx = va_r[38:30];
      LVL_1:   idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  assign walk_full   = {frame_r, idx};
  assign write_full  = FULL_W'(in_word_index);
  assign entry_frame = mem_rdata[FRAME_LSB +: FRAME_NUM_W];

  // store port: writes only from idle, reads only while walking
  assign mem_wr_en = accept && (in_operation == OP_WRITE)
                     && (32'(in_word_index) < 32'(DEPTH));
  assign mem_rd_en = (state_r == S_READ) && !outside;
  assign mem_addr  = (state_r == S_IDLE) ? write_full[ADDR_W-1:0] : walk_full[ADDR_W-1:0];
  assign mem_wdata = in_word_value;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;
    va_nxt        = va_r;
    frame_nxt     = frame_r;
    lvl_nxt       = lvl_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_WRITE) begin
            out_valid_nxt = 1'b1;
            result_nxt    = '{status: ST_WRITE, leaf_entry_address: '0, stop_level: LVL_NONE};
          end else begin
            va_nxt    = in_virtual_address;
            frame_nxt = FRAME_NUM_W'(root_frame);
            lvl_nxt   = LVL_3;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (outside) begin
          out_valid_nxt = 1'b1;
          result_nxt    = '{status: ST_OUTSIDE, leaf_entry_address: '0, stop_level: lvl_r};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!mem_rdata[PRESENT_BIT]) begin
          out_valid_nxt = 1'b1;
          result_nxt    = '{status: ST_ABSENT, leaf_entry_address: '0, stop_level: lvl_r};
          state_nxt     = S_IDLE;
        end else if (lvl_r == LVL_1) begin
          out_valid_nxt = 1'b1;
          result_nxt    = '{status: ST_LEAF,
                            leaf_entry_address: {entry_frame, va_r[20:12], 3'b000},
                            stop_level: LVL_NONE};
          state_nxt     = S_IDLE;
        end else begin
          frame_nxt = entry_frame;
          lvl_nxt   = lvl_r - 2'd1;
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    va_r     <= va_nxt;
    frame_r  <= frame_nxt;
    lvl_r    <= lvl_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

>>> sv/page_table_walker.sv
// Page table walker over a local store of 64-bit table entries.
// Input channel (in_valid / in_stall): one transfer carries an operation.
//   A write stores in_word_value at in_word_index (ignored past the store)
//   and answers with status "write done". A walk translates
//   in_virtual_address through levels 3, 2 and 1 starting at root_frame.
// Result channel (out_valid / out_stall): one transfer per input item with
//   status, leaf_entry_address and stop_level.
// Config port (APB): root_frame at byte address 0; pready is always high.
// Timing: a write result is valid the cycle after its transfer. A walk
//   passes through S_READ (issue the read) and S_CHECK (check the registered
//   entry) for each level, then the result register; one that stops early
//   leaves from S_READ (outside the store) or S_CHECK (entry absent). The
//   single read port of the table store and the dependence of each read on
//   the previous entry serialise the levels.
// Throughput: writes can transfer every cycle while out_stall is low; a
//   walk holds off the next item until its result is registered.
// Reset: synchronous, active low; clears the sequencer, the result valid
//   and root_frame. Store contents are undefined until written.
// Stall: a pending result holds until taken; the input stalls meanwhile.
module page_table_walker #(
  parameter int FRAMES = ptw_pkg::FRAMES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic [ptw_pkg::VA_W-1:0]           in_virtual_address,
  input  logic [ptw_pkg::WIDX_W-1:0]         in_word_index,
  input  logic [ptw_pkg::WORD_W-1:0]         in_word_value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [ptw_pkg::VA_W-1:0]           out_leaf_entry_address,
  output logic [1:0]                         out_stop_level,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ptw_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ptw_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ptw_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import ptw_pkg::*;

  localparam int ADDR_W = $clog2(FRAMES * ENTRIES_PER_FRAME);

  logic [ROOT_W-1:0] root_frame_r;
  logic              cfg_wr;
  result_t           result;
  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  // register access: decode the word index only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ROOT_FRAME);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_frame_r <= '0;
    end else if (cfg_wr) begin
      root_frame_r <= pwdata[ROOT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROOT_FRAME) ? CFG_DATA_W'(root_frame_r) : '0;

  // walk sequencer and result register
  ptw_ctrl #(
    .FRAMES (FRAMES)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .root_frame         (root_frame_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_virtual_address (in_virtual_address),
    .in_word_index      (in_word_index),
    .in_word_value      (in_word_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result         (result),
    .mem_wr_en          (mem_wr_en),
    .mem_rd_en          (mem_rd_en),
    .mem_addr           (mem_addr),
    .mem_wdata          (mem_wdata),
    .mem_rdata          (mem_rdata)
  );

  // table store with registered read
  ptw_store #(
    .FRAMES (FRAMES)
  ) u_store (
    .clk   (clk),
    .wr_en (mem_wr_en),
    .rd_en (mem_rd_en),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign out_status             = result.status;
  assign out_leaf_entry_address = result.leaf_entry_address;
  assign out_stop_level         = result.stop_level;

endmodule
